/* rtl/mslfo_pkg.sv */
// ----------------------------------------------------------------------------
// mslfo_pkg
// Shared widths, register and shape codes, and the quarter-wave sine table of
// the multi-shape low-frequency oscillator.
// ----------------------------------------------------------------------------
package mslfo_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int FRAC_BITS       = 16;

	localparam int SINE_N     = 1 << SINE_TABLE_BITS;
	localparam int SINE_DEPTH = SINE_N + 1;
	localparam int SINE_AW    = SINE_TABLE_BITS + 1;
	localparam int SINE_W     = 17;

	localparam int TIME_W  = 32;
	localparam int AMP_W   = 17;
	localparam int FREQ_W  = 24;
	localparam int PHASE_W = 16;
	localparam int PW_W    = 17;
	localparam int SHAPE_W = 3;
	localparam int LEVEL_W = 17;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// time * frequency, of which the low 32 bits are the cycle position
	localparam int POS_MUL_W = TIME_W + FREQ_W;
	localparam int POS_W     = 32;

	// second multiplier: amplitude times unit shape value or sine entry
	localparam int OPND_W = (FRAC_BITS + 1 > SINE_W) ? FRAC_BITS + 1 : SINE_W;
	localparam int MUL_W  = AMP_W + OPND_W;
	localparam int SQ_W   = FRAC_BITS + PW_W;
	localparam int SUM_W  = 35;

	localparam logic [AMP_W-1:0] AMP_UNIT = AMP_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHAPE        = 3'd0,
		REG_AMPLITUDE    = 3'd1,
		REG_FREQUENCY    = 3'd2,
		REG_PHASE_OFFSET = 3'd3,
		REG_PULSE_WIDTH  = 3'd4
	} cfg_reg_t;

	typedef enum logic [SHAPE_W-1:0] {
		SHAPE_SINE     = 3'd0,
		SHAPE_TRIANGLE = 3'd1,
		SHAPE_SAW_UP   = 3'd2,
		SHAPE_SAW_DOWN = 3'd3,
		SHAPE_SQUARE   = 3'd4
	} shape_t;

	// Table generation, evaluated at elaboration only
	localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
	localparam logic [63:0] Q30One    = 64'd1 << 30;
	localparam int unsigned HornerDiv [6] = '{156, 110, 72, 42, 20, 6};

	typedef logic [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

	function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] r;
		int          i;
		x  = (HalfPiQ30 * 64'(k) + 64'(SINE_N >> 1)) >> SINE_TABLE_BITS;
		x2 = (x * x) >> 30;
		t  = Q30One;
		for (i = 0; i < 6; i++)
			t = Q30One - (((x2 * t) >> 30) / 64'(HornerDiv[i]));
		s = (x * t) >> 30;
		r = (s + 64'd8192) >> 14;
		if (r > 64'd65536)
			r = 64'd65536;
		return r[SINE_W-1:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		int        k;
		for (k = 0; k < SINE_DEPTH; k++)
			rom[k] = quarter_sine(k);
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* rtl/mslfo_ram.sv */
// ----------------------------------------------------------------------------
// mslfo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mslfo_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* rtl/multi_shape_lfo_unit.sv */
// ----------------------------------------------------------------------------
// multi_shape_lfo_unit
// Low-frequency oscillator: sine, triangle, saw up, saw down and square.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_axis side carries one Q16.16 time value; each
//   transfer on the m_axis side returns the Q1.16 modulation level for it,
//   in order. Shape, amplitude, frequency, phase offset and pulse width are
//   set through the write port (cfg_wr_en, cfg_addr, cfg_wdata) while no
//   item is in flight; writes to unused indexes are dropped.
//   One item is taken every cycle while the receiver accepts each result.
//   The pipeline runs time*frequency, then the sine RAM read and shape
//   decode, then amplitude scaling, then the final offset and output
//   register.
//   After reset the sine RAM is loaded from the quarter-wave table, one
//   entry per cycle, 1025 entries in all; s_axis_tready stays low until the
//   load is done. Register writes are taken during the load as ever.
//   When the receiver stalls, the result holds in the output register and
//   the stages behind it keep filling; input is refused once every stage
//   holds an item.
// ----------------------------------------------------------------------------
module multi_shape_lfo_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_wr_en,
	input  logic [mslfo_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [mslfo_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [mslfo_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [31:0] time_req
	// output stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [mslfo_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [16:0] level, rest zero
);

	import mslfo_pkg::*;

	// configuration registers
	logic [SHAPE_W-1:0] shape_q;
	logic [AMP_W-1:0]   amp_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PW_W-1:0]    pw_q;

	// table load
	logic [SINE_AW-1:0] fill_cnt_q;
	logic               fill_done_q;

	// pipeline
	logic               vld_s1, vld_s2, vld_s3;
	logic [POS_W-1:0]   pos_s1;
	logic [OPND_W-1:0]  u_s2;
	logic               neg_s2, neg_s3;
	logic [SINE_W-1:0]  sine_s2;
	logic [MUL_W-1:0]   prod_s3;
	logic               out_vld_q;
	logic [LEVEL_W-1:0] level_q;

	logic en_out, en3, en2, en1;
	logic [POS_MUL_W-1:0] pos_full;
	logic [POS_W-1:0]     cyc;
	logic [FRAC_BITS-1:0] p;
	logic [OPND_W-1:0]    p_ext, one, half, u_next;
	logic [SINE_TABLE_BITS+1:0] q;
	logic [SINE_TABLE_BITS-1:0] k;
	logic [SINE_AW-1:0]   rd_idx;
	logic [AMP_W-1:0]     amp_sat;
	logic [OPND_W-1:0]    opnd;
	logic [SUM_W-1:0]     base, sine_sum;
	logic [LEVEL_W-1:0]   level_next;

	// ready ripples back so empty stages fill while the output is held
	assign en_out = !out_vld_q || m_axis_tready;
	assign en3    = !vld_s3 || en_out;
	assign en2    = !vld_s2 || en3;
	assign en1    = !vld_s1 || en2;

	assign s_axis_tready = fill_done_q && en1;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TDATA_W'(level_q);

	// configuration and table load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q     <= SHAPE_SINE;
			amp_q       <= AMP_UNIT;
			freq_q      <= FREQ_W'(65536);
			phase_q     <= '0;
			pw_q        <= PW_W'(32768);
			fill_cnt_q  <= '0;
			fill_done_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_SHAPE:        shape_q <= cfg_wdata[SHAPE_W-1:0];
					REG_AMPLITUDE:    amp_q   <= cfg_wdata[AMP_W-1:0];
					REG_FREQUENCY:    freq_q  <= cfg_wdata[FREQ_W-1:0];
					REG_PHASE_OFFSET: phase_q <= cfg_wdata[PHASE_W-1:0];
					REG_PULSE_WIDTH:  pw_q    <= cfg_wdata[PW_W-1:0];
					default: ;
				endcase
			end
			if (!fill_done_q) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;
				if (fill_cnt_q == SINE_AW'(SINE_N))
					fill_done_q <= 1'b1;
			end
		end
	end

	// stage 1: cycle position
	assign pos_full = POS_MUL_W'(s_axis_tdata) * POS_MUL_W'(freq_q);

	// stage 1 -> 2: table address and unit shape value
	always_comb begin
		cyc    = pos_s1 + {phase_q, 16'd0};
		p      = cyc[POS_W-1 -: FRAC_BITS];
		p_ext  = OPND_W'(p);
		one    = OPND_W'(1) << FRAC_BITS;
		half   = one >> 1;
		q      = pos_s1[POS_W-1 -: SINE_TABLE_BITS+2];
		k      = q[SINE_TABLE_BITS-1:0];
		// odd quadrants run the table backwards
		rd_idx = q[SINE_TABLE_BITS] ? SINE_AW'(SINE_N) - {1'b0, k} : {1'b0, k};
		case (shape_q)
			SHAPE_TRIANGLE: u_next = (p_ext >= half) ? (p_ext - half) << 1
			                                          : (half - p_ext) << 1;
			SHAPE_SAW_UP:   u_next = p_ext;
			SHAPE_SAW_DOWN: u_next = one - p_ext;
			SHAPE_SQUARE:   u_next = (SQ_W'({p, 16'd0}) < {pw_q, {FRAC_BITS{1'b0}}})
			                         ? one : '0;
			default:        u_next = '0;
		endcase
	end

	mslfo_ram #(
		.WIDTH(SINE_W),
		.DEPTH(SINE_DEPTH)
	) u_sine_ram (
		.clk  (clk),
		.we   (!fill_done_q),
		.waddr(fill_cnt_q),
		.wdata(SINE_ROM[fill_cnt_q]),
		.re   (en2),
		.raddr(rd_idx),
		.rdata(sine_s2)
	);

	// stage 2 -> 3: amplitude scaling
	always_comb begin
		amp_sat = (amp_q > AMP_UNIT) ? AMP_UNIT : amp_q;
		opnd    = (shape_q == SHAPE_SINE) ? OPND_W'(sine_s2) : u_s2;
	end

	// stage 3 -> output: sine offset or fraction shift
	always_comb begin
		base     = SUM_W'({phase_q, 16'd0}) + (SUM_W'(1) << 32);
		sine_sum = neg_s3 ? base - SUM_W'(prod_s3) : base + SUM_W'(prod_s3);
		case (shape_q)
			SHAPE_SINE:     level_next = sine_sum[17 +: LEVEL_W];
			SHAPE_TRIANGLE,
			SHAPE_SAW_UP,
			SHAPE_SAW_DOWN,
			SHAPE_SQUARE:   level_next = prod_s3[FRAC_BITS +: LEVEL_W];
			default:        level_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en1)
				vld_s1 <= s_axis_tvalid && s_axis_tready;
			if (en2)
				vld_s2 <= vld_s1;
			if (en3)
				vld_s3 <= vld_s2;
			if (en_out)
				out_vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1)
			pos_s1 <= pos_full[POS_W-1:0];
		if (en2) begin
			u_s2   <= u_next;
			neg_s2 <= q[SINE_TABLE_BITS+1];
		end
		if (en3) begin
			prod_s3 <= MUL_W'(amp_sat) * MUL_W'(opnd);
			neg_s3  <= neg_s2;
		end
		if (en_out)
			level_q <= level_next;
	end

endmodule

/* dv/multi_shape_lfo_unit_test.sv */
// ----------------------------------------------------------------------------
// multi_shape_lfo_unit_test
// Drives Q16.16 time values into the oscillator under a sequence of register
// settings and checks every returned level. A local model rebuilds the
// quarter-wave sine table and computes each level from a shadow copy of the
// registers. Both stream sides idle at random, in several patterns.
// ----------------------------------------------------------------------------
module multi_shape_lfo_unit_test;

	import mslfo_pkg::*;

	localparam int WAVE_BITS   = 10;
	localparam int WAVE_N      = 1 << WAVE_BITS;
	localparam int SHAPE_CODES = 1 << SHAPE_W;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 6;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] HALF_PI = 64'd1686629713;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr      = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] time_req
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [16:0] level

	multi_shape_lfo_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow registers, reset values
	logic [SHAPE_W-1:0] lfo_shape = SHAPE_SINE;
	logic [AMP_W-1:0]   lfo_amp   = 17'd65536;
	logic [FREQ_W-1:0]  lfo_freq  = 24'd65536;
	logic [PHASE_W-1:0] lfo_phase = '0;
	logic [PW_W-1:0]    lfo_pw    = 17'd32768;

	logic [SINE_W-1:0]  quarter_wave [0:WAVE_N];
	logic [TIME_W-1:0]  pending_times [$];
	logic [LEVEL_W-1:0] expected_levels [$];
	logic [LEVEL_W-1:0] want_level;
	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;
	int                 errors         = 0;
	int                 cycles         = 0;

	function automatic logic [LEVEL_W-1:0] lfo_level(input logic [TIME_W-1:0] t);
		logic [55:0]           prod;
		logic [31:0]           sine_pos;
		logic [31:0]           cyc;
		logic [AMP_W-1:0]      amp;
		logic [16:0]           p;
		logic [16:0]           u;
		logic [WAVE_BITS+1:0]  q;
		logic [WAVE_BITS:0]    idx;
		longint                acc;
		prod     = 56'(t) * 56'(lfo_freq);
		sine_pos = prod[31:0];
		cyc      = sine_pos + {lfo_phase, 16'h0000};
		amp      = (lfo_amp > 17'd65536) ? 17'd65536 : lfo_amp;
		p        = {1'b0, cyc[31:16]};
		q        = sine_pos[31:32-(WAVE_BITS+2)];
		idx      = q[WAVE_BITS] ? (WAVE_BITS+1)'(WAVE_N - q[WAVE_BITS-1:0])
		                        : {1'b0, q[WAVE_BITS-1:0]};
		u        = '0;
		acc      = 0;
		case (lfo_shape)
			SHAPE_SINE: begin
				acc = longint'(quarter_wave[idx]);
				if (q[WAVE_BITS+1])
					acc = -acc;
				acc = longint'(amp) * acc + (longint'(lfo_phase) <<< 16) + (64'sd1 <<< 32);
				acc = acc >>> 17;
			end
			SHAPE_TRIANGLE: begin
				u = (p >= 17'd32768) ? 17'(2 * (p - 17'd32768)) : 17'(2 * (17'd32768 - p));
				acc = (longint'(amp) * longint'(u)) >>> FRAC_BITS;
			end
			SHAPE_SAW_UP: begin
				acc = (longint'(amp) * longint'(p)) >>> FRAC_BITS;
			end
			SHAPE_SAW_DOWN: begin
				u = 17'd65536 - p;
				acc = (longint'(amp) * longint'(u)) >>> FRAC_BITS;
			end
			SHAPE_SQUARE: begin
				u = (p < lfo_pw) ? 17'd65536 : 17'd0;
				acc = (longint'(amp) * longint'(u)) >>> FRAC_BITS;
			end
			default: acc = 0;
		endcase
		return acc[LEVEL_W-1:0];
	endfunction

	// input side: one transfer per handshake, random gaps between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_levels.push_back(lfo_level(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_times.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pending_times.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: check each transfer against the oldest expected level
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_levels.size() == 0) begin
					$display("%0t: unexpected level, expected none, got %h", $time, m_axis_tdata);
					errors++;
				end else begin
					want_level = expected_levels.pop_front();
					if (m_axis_tdata !== OUT_TDATA_W'(want_level)) begin
						$display("%0t: level mismatch, expected %h, got %h",
						         $time, OUT_TDATA_W'(want_level), m_axis_tdata);
						errors++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("multi_shape_lfo_unit_test failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SHAPE:        lfo_shape = val[SHAPE_W-1:0];
			REG_AMPLITUDE:    lfo_amp   = val[AMP_W-1:0];
			REG_FREQUENCY:    lfo_freq  = val[FREQ_W-1:0];
			REG_PHASE_OFFSET: lfo_phase = val[PHASE_W-1:0];
			REG_PULSE_WIDTH:  lfo_pw    = val[PW_W-1:0];
			default: ;
		endcase
	endtask

	// dirty: fill the bits above each register's width with noise
	task automatic program_lfo(input logic [SHAPE_W-1:0] shp, input logic [AMP_W-1:0] amp,
	                           input logic [FREQ_W-1:0] freq, input logic [PHASE_W-1:0] phs,
	                           input logic [PW_W-1:0] pw, input bit dirty);
		logic [CFG_DATA_W-1:0] junk;
		junk = dirty ? CFG_DATA_W'($urandom) : '0;
		write_reg(REG_SHAPE,        CFG_DATA_W'(shp)  | (junk & ~24'h000007));
		write_reg(REG_AMPLITUDE,    CFG_DATA_W'(amp)  | (junk & ~24'h01FFFF));
		write_reg(REG_FREQUENCY,    CFG_DATA_W'(freq));
		write_reg(REG_PHASE_OFFSET, CFG_DATA_W'(phs)  | (junk & ~24'h00FFFF));
		write_reg(REG_PULSE_WIDTH,  CFG_DATA_W'(pw)   | (junk & ~24'h01FFFF));
		// unused index, must be dropped
		write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, SHAPE_CODES - 1)),
		          CFG_DATA_W'($urandom));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
			default: begin send_idle_pct = 34; recv_stall_pct = 34; end
		endcase
	endtask

	// wait until every accepted time has produced its level
	task automatic drain();
		@(negedge clk);
		while (pending_times.size() != 0 || expected_levels.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] corner_or_random(input logic [CFG_DATA_W-1:0] top,
	                                                           input logic [CFG_DATA_W-1:0] unit);
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return unit;
			2:       return CFG_DATA_W'($urandom_range(0, unit));
			default: return CFG_DATA_W'($urandom_range(0, top));
		endcase
	endfunction

	initial begin : stimulus
		int          sc;
		int          ph;
		int          k;
		int          m;
		logic [63:0] ang;
		logic [63:0] ang_sq;
		logic [63:0] poly;
		logic [63:0] sn;
		// quarter-wave table: Taylor series in Q30, Horner form, rounded to Q1.16
		for (k = 0; k <= WAVE_N; k++) begin
			ang    = (HALF_PI * 64'(k) + 64'(WAVE_N / 2)) >> WAVE_BITS;
			ang_sq = (ang * ang) >> 30;
			poly   = Q30_ONE;
			for (m = 6; m >= 1; m--)
				poly = Q30_ONE - (((ang_sq * poly) >> 30) / 64'(2 * m * (2 * m + 1)));
			sn = (((ang * poly) >> 30) + 64'd8192) >> 14;
			quarter_wave[k] = (sn > 64'd65536) ? 17'd65536 : sn[SINE_W-1:0];
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every shape code, register extremes, cycle edges
		for (sc = 0; sc < SHAPE_CODES; sc++) begin
			set_idling(sc % 4);
			case (SHAPE_W'(sc))
				SHAPE_SINE:     program_lfo(SHAPE_W'(sc), 17'd65536,  24'd65536,   16'd65535,
				                            17'd32768, 1'b0);
				// amplitude saturates at one
				SHAPE_TRIANGLE: program_lfo(SHAPE_W'(sc), 17'd131071, 24'd65536,   16'd0,
				                            17'd32768, 1'b0);
				SHAPE_SAW_UP:   program_lfo(SHAPE_W'(sc), 17'd65536,  24'hFFFFFF,  16'd65535,
				                            17'd0, 1'b0);
				SHAPE_SAW_DOWN: program_lfo(SHAPE_W'(sc), 17'd65535,  24'd1,       16'd32768,
				                            17'd65536, 1'b0);
				// pulse width above one: high for the whole cycle
				SHAPE_SQUARE:   program_lfo(SHAPE_W'(sc), 17'd65536,  24'd65536,   16'd16384,
				                            17'd131071, 1'b0);
				default:        program_lfo(SHAPE_W'(sc), 17'd65536,  24'd65536,   16'd0,
				                            17'd32768, 1'b0);
			endcase
			@(negedge clk);
			pending_times.push_back(32'h0000_0000);
			pending_times.push_back(32'hFFFF_FFFF);
			pending_times.push_back(32'h0000_4000);
			drain();
		end

		// random settings and times; the first ten walk through the valid shapes
		for (ph = 0; ph < 12; ph++) begin
			set_idling(ph % 4);
			program_lfo((ph < 10) ? SHAPE_W'(ph % 5) : SHAPE_W'($urandom_range(0, SHAPE_CODES - 1)),
			            AMP_W'(corner_or_random(24'h01FFFF, 24'h010000)),
			            FREQ_W'(corner_or_random(24'hFFFFFF, 24'h010000)),
			            PHASE_W'(corner_or_random(24'h00FFFF, 24'h00FFFF)),
			            PW_W'(corner_or_random(24'h01FFFF, 24'h010000)),
			            ph[0]);
			@(negedge clk);
			repeat (90) begin
				if ($urandom_range(0, 3) == 0)
					pending_times.push_back(TIME_W'($urandom_range(0, 32'h0003_FFFF)));
				else
					pending_times.push_back($urandom);
			end
			drain();
		end

		if (errors == 0)
			$display("multi_shape_lfo_unit_test passed");
		else
			$display("multi_shape_lfo_unit_test failed");
		$finish;
	end

endmodule
